>>> hdl/assert_macros.svh
// Assertion macros shared by the RTL.
// Standalone; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge of clk, disabled while rst_n is low.
`define DPM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that cons holds in the cycle after trig, disabled while rst_n is low.
`define DPM_ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/dpm_pkg.sv
// Shared types, codes and constants of the DEC private mode tracker.
// No dependencies.
`timescale 1ns / 1ps

package dpm_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int MODE_BITS     = 16;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int BUILTIN_COUNT = 6;

    localparam logic [2:0] OP_SCAN    = 3'd0;
    localparam logic [2:0] OP_SET     = 3'd1;
    localparam logic [2:0] OP_TOGGLE  = 3'd2;
    localparam logic [2:0] OP_TRACK   = 3'd3;
    localparam logic [2:0] OP_UNTRACK = 3'd4;
    localparam logic [2:0] OP_QUERY   = 3'd5;
    localparam logic [2:0] OP_CLEAR   = 3'd6;
    localparam logic [2:0] OP_NOP     = 3'd7;

    localparam logic [1:0] ST_UNSEEN = 2'd0;
    localparam logic [1:0] ST_RESET  = 2'd1;
    localparam logic [1:0] ST_SET    = 2'd2;

    localparam logic [1:0] STS_OK       = 2'd0;
    localparam logic [1:0] STS_NOTFOUND = 2'd1;
    localparam logic [1:0] STS_FULL     = 2'd2;

    localparam logic [7:0] CH_ESC   = 8'h1b;
    localparam logic [7:0] CH_BRK   = 8'h5b;
    localparam logic [7:0] CH_QST   = 8'h3f;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_H     = 8'h68;
    localparam logic [7:0] CH_L     = 8'h6c;

    typedef struct packed {
        logic [MODE_BITS-1:0] mode;
        logic                 default_set;
        logic                 tracked;
        logic [1:0]           state;
    } entry_t;

    typedef struct packed {
        logic                 complete;
        logic                 set;
        logic                 overflow;
        logic [MODE_BITS-1:0] mode;
    } seq_evt_t;

    function automatic entry_t reset_entry(input logic [IDX_W-1:0] idx);
        entry_t e;
        e.default_set = (idx == '0);
        e.tracked     = (int'(idx) < BUILTIN_COUNT);
        e.state       = ST_UNSEEN;
        case (int'(idx))
            0:       e.mode = MODE_BITS'(25);
            1:       e.mode = MODE_BITS'(1049);
            2:       e.mode = MODE_BITS'(2004);
            3:       e.mode = MODE_BITS'(1004);
            4:       e.mode = MODE_BITS'(1000);
            5:       e.mode = MODE_BITS'(1006);
            default: e.mode = '0;
        endcase
        return e;
    endfunction

endpackage

>>> hdl/dpm_table.sv
// Mode table memory: one read port with registered data, one write port.
// Depends on dpm_pkg.
`timescale 1ns / 1ps

module dpm_table (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [dpm_pkg::IDX_W-1:0]   rd_addr,
    output dpm_pkg::entry_t             rd_data,
    input  logic                        wr_en,
    input  logic [dpm_pkg::IDX_W-1:0]   wr_addr,
    input  dpm_pkg::entry_t             wr_data
);

    dpm_pkg::entry_t                       mem [dpm_pkg::TABLE_ENTRIES];
    dpm_pkg::entry_t                       rd_q_reg;
    logic [dpm_pkg::IDX_W-1:0]             addr_q_reg;
    logic                                  rd_valid_reg;
    logic [dpm_pkg::TABLE_ENTRIES-1:0]     valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_q_reg   <= mem[rd_addr];
        addr_q_reg <= rd_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= valid_reg[rd_addr];
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // Never-written entries read as their reset contents
    assign rd_data = rd_valid_reg ? rd_q_reg : dpm_pkg::reset_entry(addr_q_reg);

endmodule

>>> hdl/dpm_parser.sv
// Escape sequence parser for ESC [ ? digits h/l.
// Depends on dpm_pkg.
`timescale 1ns / 1ps

module dpm_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          data_byte,
    input  logic                end_of_buffer,
    output dpm_pkg::seq_evt_t   evt
);

    typedef enum logic [4:0] {
        P_IDLE = 5'b00001,
        P_ESC  = 5'b00010,
        P_BRK  = 5'b00100,
        P_QST  = 5'b01000,
        P_DIG  = 5'b10000
    } phase_t;

    localparam int ACC_W = dpm_pkg::MODE_BITS + 4;

    phase_t                          phase_reg, phase_next;
    logic [dpm_pkg::MODE_BITS-1:0]   acc_reg, acc_next;
    logic                            ovf_reg, ovf_next;
    logic                            is_digit;
    logic [3:0]                      digit;
    logic [ACC_W-1:0]                acc10;

    assign is_digit = (data_byte >= dpm_pkg::CH_ZERO) && (data_byte <= dpm_pkg::CH_NINE);
    assign digit    = 4'(data_byte - dpm_pkg::CH_ZERO);
    assign acc10    = {acc_reg, 3'b000} + {2'b00, acc_reg, 1'b0} + ACC_W'(digit);

    always_comb
    begin
        phase_next   = P_IDLE;
        acc_next     = acc_reg;
        ovf_next     = ovf_reg;
        evt.complete = 1'b0;
        evt.set      = (data_byte == dpm_pkg::CH_H);
        evt.overflow = ovf_reg;
        evt.mode     = acc_reg;
        if (data_byte == dpm_pkg::CH_ESC)
        begin
            phase_next = P_ESC;
        end
        else
        begin
            unique case (phase_reg)
                P_ESC:
                begin
                    if (data_byte == dpm_pkg::CH_BRK)
                        phase_next = P_BRK;
                end
                P_BRK:
                begin
                    if (data_byte == dpm_pkg::CH_QST)
                        phase_next = P_QST;
                end
                P_QST:
                begin
                    if (is_digit)
                    begin
                        acc_next   = dpm_pkg::MODE_BITS'(digit);
                        ovf_next   = 1'b0;
                        phase_next = P_DIG;
                    end
                end
                P_DIG:
                begin
                    if (is_digit)
                    begin
                        phase_next = P_DIG;
                        // saturate on overflow and keep it sticky
                        if (acc10[ACC_W-1:dpm_pkg::MODE_BITS] != '0)
                        begin
                            acc_next = '1;
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            acc_next = acc10[dpm_pkg::MODE_BITS-1:0];
                        end
                    end
                    else if (data_byte == dpm_pkg::CH_H || data_byte == dpm_pkg::CH_L)
                    begin
                        evt.complete = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = P_IDLE;
                end
            endcase
        end
        if (end_of_buffer)
            phase_next = P_IDLE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_IDLE;
            acc_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

>>> hdl/dec_private_mode_tracker.sv
// DEC private mode tracker: accepts one item per transfer on the input channel
// (opcode, data_byte, end_of_buffer, mode_number, req_state) and returns one
// result per item on the output channel (status, mode_state, dirty and the
// seq_* fields). Both channels use valid/ready.
// Scan items that do not finish a sequence or finish one with an overflowed
// mode number, clear dirty and unused opcodes skip the table and go straight
// to the done state; the next transfer in can follow once the result is
// loaded. Items that need the table walk it one entry at a time (synchronous
// read, then compare); a miss walks all n entries, n being the entry count
// (6 after reset, at most 64). One item is in the walk at a time; the next
// item can transfer in while the previous result waits in the output register.
// Reset clears the parser, the dirty flag and the entry count to the six
// built-in modes; the table reads its built-in contents through per-entry
// valid bits, so no clearing pass is needed.
// When the receiver stalls, the result holds and the walk stops at its end.
// Depends on dpm_pkg, dpm_table, dpm_parser and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dec_private_mode_tracker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [2:0]                        opcode,
    input  logic [7:0]                        data_byte,
    input  logic                              end_of_buffer,
    input  logic [dpm_pkg::MODE_BITS-1:0]     mode_number,
    input  logic                              req_state,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [1:0]                        status,
    output logic [1:0]                        mode_state,
    output logic                              dirty,
    output logic                              seq_complete,
    output logic [dpm_pkg::MODE_BITS-1:0]     seq_mode,
    output logic                              seq_set,
    output logic                              seq_applied
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_CMP  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t                            state_reg, state_next;
    logic [dpm_pkg::CNT_W-1:0]         count_reg, count_next;
    logic [dpm_pkg::CNT_W-1:0]         idx_reg, idx_next;
    logic                              dirty_reg, dirty_next;
    logic [2:0]                        op_reg, op_next;
    logic [dpm_pkg::MODE_BITS-1:0]     key_reg, key_next;
    logic                              want_reg, want_next;
    logic                              sc_reg, sc_next;
    logic [dpm_pkg::MODE_BITS-1:0]     sm_reg, sm_next;
    logic                              ss_reg, ss_next;
    logic                              app_reg, app_next;
    logic [1:0]                        sts_reg, sts_next;
    logic [1:0]                        mst_reg, mst_next;
    logic                              out_valid_reg;
    logic [1:0]                        status_reg, mode_state_reg;
    logic                              dirty_out_reg, seq_complete_reg, seq_set_reg;
    logic                              seq_applied_reg;
    logic [dpm_pkg::MODE_BITS-1:0]     seq_mode_reg;

    logic                              accept;
    logic                              load_out;
    dpm_pkg::seq_evt_t                 evt;
    dpm_pkg::entry_t                   rd_data, wr_data, ne;
    logic                              wr_en;
    logic [dpm_pkg::IDX_W-1:0]         wr_addr;
    logic [1:0]                        want_st;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || out_ready);
    assign want_st  = want_reg ? dpm_pkg::ST_SET : dpm_pkg::ST_RESET;

    dpm_parser u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (accept && opcode == dpm_pkg::OP_SCAN),
        .data_byte     (data_byte),
        .end_of_buffer (end_of_buffer),
        .evt           (evt)
    );

    dpm_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (idx_reg[dpm_pkg::IDX_W-1:0]),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        dirty_next = dirty_reg;
        op_next    = op_reg;
        key_next   = key_reg;
        want_next  = want_reg;
        sc_next    = sc_reg;
        sm_next    = sm_reg;
        ss_next    = ss_reg;
        app_next   = app_reg;
        sts_next   = sts_reg;
        mst_next   = mst_reg;
        wr_en      = 1'b0;
        wr_addr    = idx_reg[dpm_pkg::IDX_W-1:0];
        ne         = rd_data;
        wr_data    = rd_data;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next   = opcode;
                    idx_next  = '0;
                    app_next  = 1'b0;
                    sts_next  = dpm_pkg::STS_OK;
                    mst_next  = dpm_pkg::ST_UNSEEN;
                    sc_next   = 1'b0;
                    sm_next   = '0;
                    ss_next   = 1'b0;
                    key_next  = mode_number;
                    want_next = req_state;
                    state_next = S_DONE;
                    unique case (opcode) inside
                        dpm_pkg::OP_SCAN:
                        begin
                            key_next  = evt.mode;
                            want_next = evt.set;
                            if (evt.complete)
                            begin
                                sc_next = 1'b1;
                                sm_next = evt.mode;
                                ss_next = evt.set;
                                if (!evt.overflow)
                                    state_next = S_READ;
                            end
                        end
                        dpm_pkg::OP_SET, dpm_pkg::OP_TOGGLE, dpm_pkg::OP_TRACK,
                        dpm_pkg::OP_UNTRACK, dpm_pkg::OP_QUERY:
                        begin
                            state_next = S_READ;
                        end
                        dpm_pkg::OP_CLEAR:
                        begin
                            dirty_next = 1'b0;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                if (idx_reg == count_reg)
                begin
                    // miss: append on track (or report full), report not found for non-scan ops
                    state_next = S_DONE;
                    if (op_reg == dpm_pkg::OP_TRACK)
                    begin
                        if (count_reg < dpm_pkg::CNT_W'(dpm_pkg::TABLE_ENTRIES))
                        begin
                            wr_en               = 1'b1;
                            wr_addr             = count_reg[dpm_pkg::IDX_W-1:0];
                            wr_data.mode        = key_reg;
                            wr_data.default_set = 1'b0;
                            wr_data.tracked     = 1'b1;
                            wr_data.state       = dpm_pkg::ST_UNSEEN;
                            count_next          = count_reg + 1'b1;
                        end
                        else
                        begin
                            sts_next = dpm_pkg::STS_FULL;
                        end
                    end
                    else if (op_reg != dpm_pkg::OP_SCAN)
                    begin
                        sts_next = dpm_pkg::STS_NOTFOUND;
                    end
                end
                else
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (rd_data.mode == key_reg)
                begin
                    case (op_reg)
                        dpm_pkg::OP_SCAN:
                        begin
                            if (rd_data.tracked && rd_data.state != want_st)
                            begin
                                ne.state   = want_st;
                                dirty_next = 1'b1;
                                app_next   = 1'b1;
                            end
                        end
                        dpm_pkg::OP_SET:
                        begin
                            if (rd_data.state != want_st)
                            begin
                                ne.state   = want_st;
                                dirty_next = 1'b1;
                            end
                        end
                        dpm_pkg::OP_TOGGLE:
                        begin
                            if (rd_data.state == dpm_pkg::ST_UNSEEN)
                                ne.state = rd_data.default_set ? dpm_pkg::ST_RESET
                                                               : dpm_pkg::ST_SET;
                            else
                                ne.state = (rd_data.state == dpm_pkg::ST_SET)
                                           ? dpm_pkg::ST_RESET : dpm_pkg::ST_SET;
                            dirty_next = 1'b1;
                        end
                        dpm_pkg::OP_TRACK:   ne.tracked = 1'b1;
                        dpm_pkg::OP_UNTRACK: ne.tracked = 1'b0;
                        default:             ne = rd_data;
                    endcase
                    wr_en      = 1'b1;
                    wr_data    = ne;
                    mst_next   = ne.state;
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_READ;
                end
            end
            S_DONE:
            begin
                if (load_out)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= dpm_pkg::CNT_W'(dpm_pkg::BUILTIN_COUNT);
            dirty_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            dirty_reg <= dirty_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        op_reg   <= op_next;
        key_reg  <= key_next;
        want_reg <= want_next;
        sc_reg   <= sc_next;
        sm_reg   <= sm_next;
        ss_reg   <= ss_next;
        app_reg  <= app_next;
        sts_reg  <= sts_next;
        mst_reg  <= mst_next;
        if (load_out)
        begin
            status_reg       <= sts_reg;
            mode_state_reg   <= mst_reg;
            dirty_out_reg    <= dirty_reg;
            seq_complete_reg <= sc_reg;
            seq_mode_reg     <= sm_reg;
            seq_set_reg      <= ss_reg;
            seq_applied_reg  <= app_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign mode_state   = mode_state_reg;
    assign dirty        = dirty_out_reg;
    assign seq_complete = seq_complete_reg;
    assign seq_mode     = seq_mode_reg;
    assign seq_set      = seq_set_reg;
    assign seq_applied  = seq_applied_reg;

    `DPM_ASSERT(a_count_bound, clk, rst_n,
        count_reg <= dpm_pkg::CNT_W'(dpm_pkg::TABLE_ENTRIES), "entry count past table size")
    `DPM_ASSERT(a_write_in_walk, clk, rst_n,
        wr_en |-> (state_reg == S_READ || state_reg == S_CMP), "table write outside walk")
    `DPM_ASSERT_NEXT(a_done_holds, clk, rst_n,
        state_reg == S_DONE && out_valid_reg && !out_ready, state_reg == S_DONE,
        "result dropped while output stalled")
    `DPM_ASSERT(a_idx_bound, clk, rst_n,
        idx_reg <= count_reg || state_reg == S_IDLE || state_reg == S_DONE,
        "walk index past entry count")

endmodule
